FILE: src/rgim_pkg.sv
// Shared types and constants for the ROI to ground-truth IoU matcher.
`timescale 1ns / 1ps
package rgim_pkg;

	localparam int COORD_W  = 16;
	localparam int LABEL_W  = 8;
	localparam int IOU_W    = 17;
	localparam int OUT_IDX_W = 6;
	localparam logic [COORD_W+1:0] PIX_ONE = 18'd16;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CLS_FG    = 2'd0,
		CLS_BG    = 2'd1,
		CLS_OTHER = 2'd2
	} roi_class_t;

	typedef enum logic [1:0] {
		REG_FG_THRESHOLD = 2'd0,
		REG_BG_UPPER     = 2'd1,
		REG_BG_LOWER     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
	} box_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		box_t               box;
	} gt_entry_t;

	typedef struct packed {
		logic             done;
		logic [IOU_W-1:0] iou;
	} iou_res_t;

endpackage

FILE: src/rgim_table.sv
// Ground-truth box table: one write port, one registered read port.
`timescale 1ns / 1ps
module rgim_table
	import rgim_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  gt_entry_t        wdata,
	input  logic [IDX_W-1:0] raddr,
	output gt_entry_t        rdata
);

	gt_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/rgim_iou.sv
// IoU of one box pair: three pipeline stages, then a 17-step restoring divider.
`timescale 1ns / 1ps
module rgim_iou
	import rgim_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  box_t     qbox,
	input  box_t     gbox,
	output iou_res_t res
);

	localparam int W = COORD_W + 2;

	logic signed [W-1:0] iw, ih, wa, ha, wb, hb;
	logic [COORD_W:0] min_x2, max_x1, min_y2, max_y1;

	logic             v_s1, v_s2, v_s3;
	logic             zero_s1, zero_s2, zero_s3;
	logic [COORD_W:0] iw_s1, ih_s1, wa_s1, ha_s1, wb_s1, hb_s1;
	logic [33:0]      inter_s2, aa_s2, ab_s2;
	logic [33:0]      inter_s3;
	logic [34:0]      uni_s3;

	logic             busy_q;
	logic [4:0]       step_q;
	logic [35:0]      rem_q;
	logic             lsb_q;
	logic [34:0]      div_q;
	logic [IOU_W-1:0] quo_q;
	logic             done_q;
	logic [36:0]      trial;
	logic [36:0]      diff;

	always_comb begin
		min_x2 = {1'b0, (qbox.right  < gbox.right)  ? qbox.right  : gbox.right};
		max_x1 = {1'b0, (qbox.left   > gbox.left)   ? qbox.left   : gbox.left};
		min_y2 = {1'b0, (qbox.bottom < gbox.bottom) ? qbox.bottom : gbox.bottom};
		max_y1 = {1'b0, (qbox.top    > gbox.top)    ? qbox.top    : gbox.top};
		iw = $signed({1'b0, min_x2}) - $signed({1'b0, max_x1}) + $signed(PIX_ONE);
		ih = $signed({1'b0, min_y2}) - $signed({1'b0, max_y1}) + $signed(PIX_ONE);
		wa = $signed({2'b0, qbox.right})  - $signed({2'b0, qbox.left}) + $signed(PIX_ONE);
		ha = $signed({2'b0, qbox.bottom}) - $signed({2'b0, qbox.top})  + $signed(PIX_ONE);
		wb = $signed({2'b0, gbox.right})  - $signed({2'b0, gbox.left}) + $signed(PIX_ONE);
		hb = $signed({2'b0, gbox.bottom}) - $signed({2'b0, gbox.top})  + $signed(PIX_ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (iw <= 0) || (ih <= 0);
		iw_s1 <= iw[COORD_W:0];
		ih_s1 <= ih[COORD_W:0];
		wa_s1 <= wa[COORD_W:0];
		ha_s1 <= ha[COORD_W:0];
		wb_s1 <= wb[COORD_W:0];
		hb_s1 <= hb[COORD_W:0];

		zero_s2  <= zero_s1;
		inter_s2 <= iw_s1 * ih_s1;
		aa_s2    <= wa_s1 * ha_s1;
		ab_s2    <= wb_s1 * hb_s1;

		zero_s3  <= zero_s2;
		inter_s3 <= inter_s2;
		uni_s3   <= {1'b0, aa_s2} + {1'b0, ab_s2} - {1'b0, inter_s2};
	end

	// numerator is inter << 16: first brought-in bit is inter[0], then zeros
	assign trial = {rem_q, (step_q == 5'd0) ? lsb_q : 1'b0};
	assign diff  = trial - {2'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (v_s3) begin
				if (zero_s3) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= '0;
				end
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(IOU_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			rem_q <= {3'b0, inter_s3[33:1]};
			lsb_q <= inter_s3[0];
			div_q <= uni_s3;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!diff[36]) begin
				rem_q <= diff[35:0];
				quo_q <= {quo_q[IOU_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[35:0];
				quo_q <= {quo_q[IOU_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.iou  = quo_q;

endmodule

FILE: src/roi_gt_iou_matcher.sv
// Top level: ground-truth table, query sequencer, result register, config regs.
`timescale 1ns / 1ps
// A load beat (tuser 0) appends a box and label to the table and is dropped when
// MAX_GT boxes are held; a clear beat (tuser 2) empties the table. A query beat
// (tuser 1) walks the stored boxes one at a time through the table's read port and
// the IoU unit: an overlapping box passes through read, start, three arithmetic
// stages, a 17-step divider and result, while a box with no overlap skips the
// divider. One query is in flight at a time and the input is held off meanwhile; a
// finished result sits in the output register while the next beat is taken, and a
// second result waits until the first one has left.
module roi_gt_iou_matcher
	import rgim_pkg::*;
#(
	parameter int MAX_GT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // left, top, right, bottom, class_label
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // best_index, best_overlap, best_label, roi_class, pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int IDX_W = (MAX_GT > 1) ? $clog2(MAX_GT) : 1;
	localparam int CNT_W = $clog2(MAX_GT + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_START  = 5'b00100,
		ST_BUSY   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] k_q;
	box_t             qbox_q;
	logic [IOU_W-1:0] best_q;
	logic [IDX_W-1:0] best_k_q;
	logic [LABEL_W-1:0] best_label_q, cur_label_q;
	logic [IOU_W-1:0] fg_thr_q, bg_up_q, bg_lo_q;

	gt_entry_t  in_entry, rd_entry;
	iou_res_t   ires;
	logic       accept, tbl_we, iou_start, res_load;
	roi_class_t cls;
	logic [IDX_W+5:0] bi_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_entry.box.left   = s_tdata[15:0];
	assign in_entry.box.top    = s_tdata[31:16];
	assign in_entry.box.right  = s_tdata[47:32];
	assign in_entry.box.bottom = s_tdata[63:48];
	assign in_entry.label      = s_tdata[71:64];
	assign tbl_we = accept && (s_tuser == MODE_LOAD) && (count_q < CNT_W'(MAX_GT));
	assign iou_start = (state_q == ST_START);
	assign res_load  = (state_q == ST_RESULT) && (!m_tvalid || m_tready);

	rgim_table #(.DEPTH(MAX_GT), .IDX_W(IDX_W)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_entry),
		.raddr (k_q),
		.rdata (rd_entry)
	);

	rgim_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (iou_start),
		.qbox   (qbox_q),
		.gbox   (rd_entry.box),
		.res    (ires)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_thr_q <= 17'd32768;
			bg_up_q  <= 17'd32768;
			bg_lo_q  <= 17'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FG_THRESHOLD: fg_thr_q <= cfg_data;
				REG_BG_UPPER:     bg_up_q  <= cfg_data;
				REG_BG_LOWER:     bg_lo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (best_q >= fg_thr_q) begin
			cls = CLS_FG;
		end else if (best_q >= bg_lo_q && best_q < bg_up_q) begin
			cls = CLS_BG;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign bi_ext = (IDX_W + 6)'(best_k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							MODE_LOAD: begin
								if (tbl_we) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							MODE_CLEAR: count_q <= '0;
							MODE_QUERY: begin
								k_q <= '0;
								state_q <= (count_q == '0) ? ST_RESULT : ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ:  state_q <= ST_START;
				ST_START: state_q <= ST_BUSY;
				ST_BUSY: begin
					if (ires.done) begin
						if (CNT_W'(k_q) == count_q - CNT_W'(1)) begin
							state_q <= ST_RESULT;
						end else begin
							k_q <= k_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_RESULT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser == MODE_QUERY) begin
			qbox_q       <= in_entry.box;
			best_q       <= '0;
			best_k_q     <= '0;
			best_label_q <= '0;
		end
		if (state_q == ST_START) begin
			cur_label_q <= rd_entry.label;
		end
		if (state_q == ST_BUSY && ires.done && (k_q == '0 || ires.iou > best_q)) begin
			best_q       <= ires.iou;
			best_k_q     <= k_q;
			best_label_q <= cur_label_q;
		end
		if (res_load) begin
			m_tdata <= {7'b0, cls, best_label_q, best_q, bi_ext[5:0]};
		end
	end

endmodule
